### rtl/core/stpa_pkg.sv
// Shared types and constants of the slot-table poll arbiter.
package stpa_pkg;

    localparam int TABLE_SIZE    = 64;
    localparam int NUM_QUEUES    = 8;
    localparam int COUNTER_WIDTH = 32;

    localparam int SLOT_W  = 6;
    localparam int QUEUE_W = 3;
    localparam int MASK_W  = 8;
    localparam int VALUE_W = 32;
    localparam int PROBE_W = SLOT_W + 1;
    localparam int SHARE_W = SLOT_W + 1;

    localparam logic [1:0] OP_POLL  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [MASK_W-1:0]  request_mask;
        logic [SLOT_W-1:0]  slot_index;
        logic [QUEUE_W-1:0] queue_id;
        logic               slot_in_use;
        logic               slot_accounted;
    } req_t;

    typedef struct packed {
        logic               granted;
        logic [QUEUE_W-1:0] grant_queue;
        logic [SLOT_W-1:0]  grant_slot;
        logic [VALUE_W-1:0] poll_value;
        logic [VALUE_W-1:0] window_value;
        logic [VALUE_W-1:0] lifetime_value;
    } rsp_t;

    typedef struct packed {
        logic               accounted;
        logic               in_use;
        logic [QUEUE_W-1:0] queue;
    } slot_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE_RD,
        ST_WRITE,
        ST_SWEEP,
        ST_UNDO,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic sweep;
        logic wr_commit;
        logic undo;
        logic rsp_load;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic last;
        logic skip_idle;
        logic rsp_free;
    } status_t;

endpackage

### rtl/core/stpa_ctrl.sv
// Controller state machine of the slot-table poll arbiter.
module stpa_ctrl
    import stpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic [1:0] req_operation,
    output logic       req_stall,
    output cmd_t       cmd,
    input  status_t    status
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (req_operation)
                        OP_POLL:  state_next = ST_SWEEP;
                        OP_WRITE: state_next = ST_WRITE_RD;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_WRITE_RD:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.wr_commit = 1'b1;
                state_next    = ST_DONE;
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                priority if (status.hit)
                begin
                    state_next = ST_DONE;
                end
                else if (status.last)
                begin
                    state_next = status.skip_idle ? ST_UNDO : ST_DONE;
                end
                else
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_UNDO:
            begin
                cmd.undo   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the result register is free
                if (status.rsp_free)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/stpa_datapath.sv
// Datapath of the slot-table poll arbiter: slot table, counters and result register.
module stpa_datapath
    import stpa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    output status_t status,
    input  req_t    req,
    input  logic    cfg_we,
    input  logic    cfg_wdata,
    output logic    rsp_valid,
    input  logic    rsp_stall,
    output rsp_t    rsp
);

    req_t                     req_reg;
    logic                     skip_idle_reg;
    logic [SLOT_W-1:0]        start_reg;
    logic [PROBE_W-1:0]       probe_cnt_reg;
    logic                     eval_valid_reg;
    logic [SLOT_W-1:0]        eval_idx_reg;

    slot_entry_t              slot_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0]    slot_valid_reg;
    slot_entry_t              rd_data_reg;
    logic                     rd_valid_reg;

    logic [COUNTER_WIDTH-1:0] poll_reg     [NUM_QUEUES];
    logic [COUNTER_WIDTH-1:0] window_reg   [NUM_QUEUES];
    logic [COUNTER_WIDTH-1:0] lifetime_reg [NUM_QUEUES];
    logic [SHARE_W-1:0]       share_reg    [NUM_QUEUES];
    logic [COUNTER_WIDTH-1:0] poll_next     [NUM_QUEUES];
    logic [COUNTER_WIDTH-1:0] window_next   [NUM_QUEUES];
    logic [COUNTER_WIDTH-1:0] lifetime_next [NUM_QUEUES];
    logic [SHARE_W-1:0]       share_next    [NUM_QUEUES];

    logic                     granted_reg;
    logic [QUEUE_W-1:0]       grant_queue_reg;
    logic [SLOT_W-1:0]        grant_slot_reg;

    logic                     rsp_valid_reg;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;

    logic [SLOT_W-1:0]        sweep_addr;
    logic [SLOT_W-1:0]        rd_addr;
    logic                     probes_left;
    logic                     issue;
    logic                     probe;
    logic                     hit;
    logic                     last;
    logic                     finish;
    logic                     charged;
    slot_entry_t              entry;
    slot_entry_t              new_entry;

    assign sweep_addr  = start_reg + probe_cnt_reg[SLOT_W-1:0];
    assign probes_left = (probe_cnt_reg != PROBE_W'(TABLE_SIZE));
    assign issue       = cmd.sweep && probes_left;
    assign rd_addr     = cmd.sweep ? sweep_addr : req_reg.slot_index;

    // a slot never written reads as empty
    assign entry   = rd_valid_reg ? rd_data_reg : '0;
    assign charged = entry.in_use && entry.accounted;
    assign probe   = cmd.sweep && eval_valid_reg;
    assign hit     = probe && entry.in_use && req_reg.request_mask[entry.queue];
    assign last    = probe && !probes_left;
    assign finish  = hit || last;

    assign new_entry.in_use    = req_reg.slot_in_use;
    assign new_entry.accounted = req_reg.slot_in_use && req_reg.slot_accounted;
    assign new_entry.queue     = req_reg.slot_in_use ? req_reg.queue_id : '0;

    assign status.hit       = hit;
    assign status.last      = last;
    assign status.skip_idle = skip_idle_reg;
    assign status.rsp_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        for (int k = 0; k < NUM_QUEUES; k++)
        begin
            poll_next[k]     = poll_reg[k];
            window_next[k]   = window_reg[k];
            lifetime_next[k] = lifetime_reg[k];
            share_next[k]    = share_reg[k];
            if (probe && charged && entry.queue == QUEUE_W'(k))
            begin
                poll_next[k] = poll_reg[k] + COUNTER_WIDTH'(1);
            end
            if (hit && charged && entry.queue == QUEUE_W'(k))
            begin
                window_next[k]   = window_reg[k] + COUNTER_WIDTH'(1);
                lifetime_next[k] = lifetime_reg[k] + COUNTER_WIDTH'(1);
            end
            // drop the charge of a sweep that found no work
            if (cmd.undo)
            begin
                poll_next[k] = poll_reg[k] - COUNTER_WIDTH'(share_reg[k]);
            end
            if (cmd.wr_commit)
            begin
                if (charged && entry.queue == QUEUE_W'(k))
                begin
                    share_next[k] = share_next[k] - SHARE_W'(1);
                end
                if (new_entry.accounted && new_entry.queue == QUEUE_W'(k))
                begin
                    share_next[k] = share_next[k] + SHARE_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        rsp_next                = '0;
        rsp_next.granted        = granted_reg;
        rsp_next.grant_queue    = grant_queue_reg;
        rsp_next.grant_slot     = grant_slot_reg;
        if (req_reg.operation == OP_READ)
        begin
            rsp_next.poll_value     = poll_reg[req_reg.queue_id][VALUE_W-1:0];
            rsp_next.window_value   = window_reg[req_reg.queue_id][VALUE_W-1:0];
            rsp_next.lifetime_value = lifetime_reg[req_reg.queue_id][VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_commit)
        begin
            slot_mem[req_reg.slot_index] <= new_entry;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_idle_reg  <= 1'b0;
            start_reg      <= '0;
            probe_cnt_reg  <= '0;
            eval_valid_reg <= 1'b0;
            slot_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            for (int k = 0; k < NUM_QUEUES; k++)
            begin
                poll_reg[k]     <= '0;
                window_reg[k]   <= '0;
                lifetime_reg[k] <= '0;
                share_reg[k]    <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                skip_idle_reg <= cfg_wdata;
            end
            if (cmd.wr_commit)
            begin
                slot_valid_reg[req_reg.slot_index] <= 1'b1;
            end
            rd_valid_reg <= slot_valid_reg[rd_addr];
            if (finish)
            begin
                start_reg      <= start_reg + SLOT_W'(1);
                probe_cnt_reg  <= '0;
                eval_valid_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    probe_cnt_reg <= probe_cnt_reg + PROBE_W'(1);
                end
                eval_valid_reg <= issue;
            end
            for (int k = 0; k < NUM_QUEUES; k++)
            begin
                poll_reg[k]     <= poll_next[k];
                window_reg[k]   <= window_next[k];
                lifetime_reg[k] <= lifetime_next[k];
                share_reg[k]    <= share_next[k];
            end
            if (cmd.rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg <= sweep_addr;
        if (cmd.load)
        begin
            req_reg         <= req;
            granted_reg     <= 1'b0;
            grant_queue_reg <= '0;
            grant_slot_reg  <= '0;
        end
        else if (hit)
        begin
            granted_reg     <= 1'b1;
            grant_queue_reg <= entry.queue;
            grant_slot_reg  <= eval_idx_reg;
        end
        if (cmd.rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/core/slot_table_poll_arbiter.sv
// Slot-table poll arbiter: a 64-entry slot table swept one slot per cycle from a
// rotating start, with per-queue poll, window and lifetime counters. A poll request
// reads one slot per clock from the table memory, pipelined behind its registered
// read. When skip_idle is set and no queue has work, the per-queue charge is undone
// after the sweep. A slot write reads the old entry, then updates it. One request
// is worked on at a time; the next one is taken while the previous result still
// waits in the output register.
module slot_table_poll_arbiter
    import stpa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    cmd_t    cmd;
    status_t status;

    stpa_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_operation (req.operation),
        .req_stall     (req_stall),
        .cmd           (cmd),
        .status        (status)
    );

    stpa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

### verif/testbench.sv
// Self-checking testbench for the slot-table poll arbiter.
`timescale 1ns / 1ps

module testbench;
    import stpa_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE       = 80;       // longest sweep plus undo, with margin
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 285;
    localparam int STEADY_ITEMS = 40;
    localparam logic [1:0] OP_NONE = 2'd3;

    // Scoreboard: predicts the arbiter's response to every accepted request.
    class grant_scoreboard;
        slot_entry_t        slots [TABLE_SIZE];
        logic [SHARE_W-1:0] share [NUM_QUEUES];
        logic [VALUE_W-1:0] polls [NUM_QUEUES];
        logic [VALUE_W-1:0] window_wins [NUM_QUEUES];
        logic [VALUE_W-1:0] lifetime_wins [NUM_QUEUES];
        logic [SLOT_W-1:0]  sweep_start;
        logic               skip_idle;
        rsp_t               expected_rsps [$];
        int                 mismatches;
        int                 sweeps;
        int                 grants;
        int                 writes;
        int                 reads;

        function new();
            for (int i = 0; i < TABLE_SIZE; i++)
                slots[i] = '0;
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                share[q]         = '0;
                polls[q]         = '0;
                window_wins[q]   = '0;
                lifetime_wins[q] = '0;
            end
            sweep_start = '0;
            skip_idle   = 1'b0;
            mismatches  = 0;
            sweeps      = 0;
            grants      = 0;
            writes      = 0;
            reads       = 0;
        endfunction

        function void set_skip_idle(logic value);
            skip_idle = value;
        endfunction

        function int pending();
            return expected_rsps.size();
        endfunction

        function void note_request(req_t r);
            rsp_t          res;
            slot_entry_t   e;
            slot_entry_t   old;
            slot_entry_t   fresh;
            logic [SLOT_W-1:0] idx;
            logic          won;
            logic          charged;

            res = '0;
            won = 1'b0;
            case (r.operation)
                OP_POLL:
                begin
                    sweeps++;
                    for (int t = 0; t < TABLE_SIZE; t++)
                    begin
                        if (!won)
                        begin
                            idx     = sweep_start + t[SLOT_W-1:0];
                            e       = slots[idx];
                            charged = e.in_use && e.accounted;
                            if (charged)
                                polls[e.queue] = polls[e.queue] + 1'b1;
                            if (e.in_use && r.request_mask[e.queue])
                            begin
                                if (charged)
                                begin
                                    window_wins[e.queue]   = window_wins[e.queue] + 1'b1;
                                    lifetime_wins[e.queue] = lifetime_wins[e.queue] + 1'b1;
                                end
                                res.granted     = 1'b1;
                                res.grant_queue = e.queue;
                                res.grant_slot  = idx;
                                won             = 1'b1;
                            end
                        end
                    end
                    // Give back the charge of a sweep that found nothing.
                    if (!won && skip_idle)
                        for (int q = 0; q < NUM_QUEUES; q++)
                            polls[q] = polls[q] - VALUE_W'(share[q]);
                    if (won)
                        grants++;
                    sweep_start = sweep_start + 1'b1;
                end
                OP_WRITE:
                begin
                    writes++;
                    old = slots[r.slot_index];
                    if (old.in_use && old.accounted)
                        share[old.queue] = share[old.queue] - 1'b1;
                    fresh = '0;
                    if (r.slot_in_use)
                    begin
                        fresh.queue     = r.queue_id;
                        fresh.in_use    = 1'b1;
                        fresh.accounted = r.slot_accounted;
                        if (r.slot_accounted)
                            share[r.queue_id] = share[r.queue_id] + 1'b1;
                    end
                    slots[r.slot_index] = fresh;
                end
                OP_READ:
                begin
                    reads++;
                    res.poll_value     = polls[r.queue_id];
                    res.window_value   = window_wins[r.queue_id];
                    res.lifetime_value = lifetime_wins[r.queue_id];
                end
                default:
                begin
                end
            endcase
            expected_rsps = {expected_rsps, res};
        endfunction

        function void compare_field(string name, logic [VALUE_W-1:0] want,
                                    logic [VALUE_W-1:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;

            if (expected_rsps.size() == 0)
            begin
                $error("response with no request pending: %h", got);
                mismatches++;
                return;
            end
            want = expected_rsps.pop_front();
            compare_field("granted", VALUE_W'(want.granted), VALUE_W'(got.granted));
            compare_field("grant_queue", VALUE_W'(want.grant_queue),
                          VALUE_W'(got.grant_queue));
            compare_field("grant_slot", VALUE_W'(want.grant_slot), VALUE_W'(got.grant_slot));
            compare_field("poll_value", want.poll_value, got.poll_value);
            compare_field("window_value", want.window_value, got.window_value);
            compare_field("lifetime_value", want.lifetime_value, got.lifetime_value);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    grant_scoreboard sb;
    int  cycle_count;
    bit  steady_traffic;

    slot_table_poll_arbiter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("testbench failed");
        $finish;
    end

    function automatic req_t make_req(logic [1:0] op, logic [MASK_W-1:0] mask,
                                      logic [SLOT_W-1:0] slot, logic [QUEUE_W-1:0] queue,
                                      logic in_use, logic accounted);
        req_t r;

        r.operation      = op;
        r.request_mask   = mask;
        r.slot_index     = slot;
        r.queue_id       = queue;
        r.slot_in_use    = in_use;
        r.slot_accounted = accounted;
        return r;
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   pick;

        r = make_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            r.operation = OP_POLL;
            // Sparse masks make the sweep run long.
            case ($urandom_range(0, 3))
                0: r.request_mask = '0;
                1: r.request_mask = 8'(1 << $urandom_range(0, 7));
                default: ;
            endcase
        end
        else if (pick < 75)
        begin
            r.operation   = OP_WRITE;
            r.slot_in_use = ($urandom_range(0, 4) != 0);
        end
        else if (pick < 95)
            r.operation = OP_READ;
        else
            r.operation = OP_NONE;
        return r;
    endfunction

    task automatic send_request(input req_t r);
        int gap;

        gap = steady_traffic ? 0 : $urandom_range(0, 7);
        repeat (gap)
        begin
            @(negedge clk);
            req_valid = 1'b0;
        end
        @(negedge clk);
        req       = r;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(r);
    endtask

    // Drop valid and hold until every response is back and the block is quiet.
    task automatic drain();
        @(negedge clk);
        req_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_skip_idle(input logic value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.set_skip_idle(value);
    endtask

    // Response side: stall a random number of cycles before each response.
    initial
    begin
        int hold;

        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = steady_traffic ? 0 : $urandom_range(0, 7);
            repeat (hold)
            begin
                @(negedge clk);
                rsp_stall = 1'b1;
            end
            @(negedge clk);
            rsp_stall = 1'b0;
            do
                @(posedge clk);
            while (!(rsp_valid && !rsp_stall));
            sb.check_response(rsp);
        end
    end

    initial
    begin
        logic skip_setting;

        sb             = new();
        cycle_count    = 0;
        steady_traffic = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, extremes of slot and queue, empty-but-accounted slot.
        send_request(make_req(OP_POLL, 8'hFF, 6'd0, 3'd0, 1'b0, 1'b0));
        send_request(make_req(OP_READ, 8'h00, 6'd0, 3'd0, 1'b0, 1'b0));
        send_request(make_req(OP_WRITE, 8'h00, 6'd0, 3'd0, 1'b1, 1'b1));
        send_request(make_req(OP_WRITE, 8'h00, 6'd63, 3'd7, 1'b1, 1'b1));
        send_request(make_req(OP_WRITE, 8'h00, 6'd5, 3'd3, 1'b1, 1'b0));
        send_request(make_req(OP_WRITE, 8'h00, 6'd10, 3'd2, 1'b0, 1'b1));
        send_request(make_req(OP_POLL, 8'hFF, 6'd0, 3'd0, 1'b0, 1'b0));
        send_request(make_req(OP_POLL, 8'h80, 6'd0, 3'd0, 1'b0, 1'b0));
        send_request(make_req(OP_POLL, 8'h00, 6'd0, 3'd0, 1'b0, 1'b0));
        send_request(make_req(OP_POLL, 8'h01, 6'd0, 3'd0, 1'b0, 1'b0));
        send_request(make_req(OP_NONE, 8'hFF, 6'd63, 3'd7, 1'b1, 1'b1));
        send_request(make_req(OP_WRITE, 8'hFF, 6'd0, 3'd0, 1'b1, 1'b0));
        send_request(make_req(OP_WRITE, 8'h00, 6'd63, 3'd7, 1'b0, 1'b0));
        for (int q = 0; q < NUM_QUEUES; q++)
            send_request(make_req(OP_READ, 8'h00, 6'd0, 3'(q), 1'b0, 1'b0));
        send_request(make_req(OP_WRITE, 8'h00, 6'd20, 3'd4, 1'b1, 1'b1));
        drain();

        // Idle sweeps with the charge given back.
        write_skip_idle(1'b1);
        send_request(make_req(OP_POLL, 8'h00, 6'd0, 3'd0, 1'b0, 1'b0));
        send_request(make_req(OP_POLL, 8'h00, 6'd63, 3'd7, 1'b1, 1'b1));
        send_request(make_req(OP_READ, 8'h00, 6'd0, 3'd4, 1'b0, 1'b0));
        send_request(make_req(OP_READ, 8'h00, 6'd0, 3'd0, 1'b0, 1'b0));
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            skip_setting = phase[0] ? 1'b0 : 1'b1;
            write_skip_idle(skip_setting);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                steady_traffic = (n < STEADY_ITEMS);
                send_request(random_request());
            end
            steady_traffic = 1'b0;
            drain();
        end

        if (sb.pending() != 0)
        begin
            $error("%0d responses never arrived", sb.pending());
            sb.mismatches++;
        end
        $display("Ran %0d sweeps (%0d granted), %0d slot writes and %0d counter reads",
                 sb.sweeps, sb.grants, sb.writes, sb.reads);
        $display("with skip_idle both clear and set, under random and steady traffic");
        if (sb.mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

### slot_table_poll_arbiter.f
rtl/core/stpa_pkg.sv
rtl/core/stpa_ctrl.sv
rtl/core/stpa_datapath.sv
rtl/core/slot_table_poll_arbiter.sv
verif/testbench.sv
